[sv/rv32x_pkg.sv]
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared constants, opcode and function codes, and the request types that
// pass between the execute top level, the register file and the data memory.
// ----------------------------------------------------------------------------
package rv32x_pkg;

    // Data memory size in bytes; must be a power of two, at least 16
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_AW    = MEM_AW - 2;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 codes for loads and stores
    localparam logic [2:0] F3_B  = 3'b000;
    localparam logic [2:0] F3_H  = 3'b001;
    localparam logic [2:0] F3_W  = 3'b010;
    localparam logic [2:0] F3_BU = 3'b100;
    localparam logic [2:0] F3_HU = 3'b101;

    // funct3 codes for register-register operations
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_SLTU = 3'b011;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    // Access size codes (low two bits of a store's funct3)
    localparam logic [1:0] SZ_BYTE = 2'b00;
    localparam logic [1:0] SZ_HALF = 2'b01;
    localparam logic [1:0] SZ_WORD = 2'b10;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [4:0]  HALT_REG    = 5'd10;

    // Register file read request (taken when an instruction is accepted)
    typedef struct packed {
        logic       en;
        logic [4:0] ra;
        logic [4:0] rb;
    } t_rf_rd;

    // Register file write request
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // Data memory request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [MEM_AW-1:0] addr;
        logic [1:0]        size;
        logic [31:0]       wdata;
    } t_mem_req;

endpackage

[sv/rv32x_regfile.sv]
// ----------------------------------------------------------------------------
// rv32x_regfile
// 32 x 32-bit register file: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rv32x_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rv32x_pkg::t_rf_rd i_rd,
    input  rv32x_pkg::t_rf_wr i_wr,
    output logic [31:0]       o_ra_data,
    output logic [31:0]       o_rb_data
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;

    // Mark entries as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Write and read the array; reads see the old contents
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_qa <= r_mem[i_rd.ra];
            r_qb <= r_mem[i_rd.rb];
            r_va <= r_valid[i_rd.ra];
            r_vb <= r_valid[i_rd.rb];
        end
    end

    // Drop stale contents of entries never written
    assign o_ra_data = r_va ? r_qa : 32'd0;
    assign o_rb_data = r_vb ? r_qb : 32'd0;

endmodule

[sv/rv32x_dmem.sv]
// ----------------------------------------------------------------------------
// rv32x_dmem
// Little-endian data memory built from four byte banks. A 1, 2 or 4 byte
// access at any byte address touches each bank at most once, wrapping at the
// end of memory. Read data is registered. After reset a clearing pass zeroes
// one row of all banks per cycle before the memory reports ready.
// ----------------------------------------------------------------------------
module rv32x_dmem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rv32x_pkg::t_mem_req i_req,
    output logic                o_ready,
    output logic [31:0]         o_rdata
);

    localparam int AW   = rv32x_pkg::MEM_AW;
    localparam int RAW  = rv32x_pkg::ROW_AW;
    localparam int ROWS = rv32x_pkg::MEM_ROWS;

    typedef enum logic [1:0] {
        MS_CLEAR = 2'b01,
        MS_RUN   = 2'b10
    } t_mem_state;

    t_mem_state       r_state;
    t_mem_state       n_state;
    logic [RAW-1:0]   r_clr_row;
    logic [RAW-1:0]   n_clr_row;
    logic [1:0]       r_lo;
    logic [3:0][7:0]  w_bank_q;

    // Sequence the clearing pass
    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        unique case (r_state)
            MS_CLEAR: begin
                n_clr_row = r_clr_row + RAW'(1);
                if (r_clr_row == RAW'(ROWS - 1)) begin
                    n_state = MS_RUN;
                end
            end
            MS_RUN: begin
                n_state = MS_RUN;
            end
            default: begin
                n_state = MS_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= MS_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
        end
    end

    assign o_ready = (r_state == MS_RUN);

    // Hold the byte lane of the first byte for read assembly
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_lo <= i_req.addr[1:0];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]     r_mem [ROWS];
        logic [7:0]     r_q;
        logic [1:0]     off;
        logic [AW-1:0]  baddr;
        logic [RAW-1:0] row;
        logic           we;
        logic [7:0]     wd;

        // Locate this bank's byte within the access
        assign off   = 2'(b) - i_req.addr[1:0];
        assign baddr = i_req.addr + AW'(off);
        assign row   = baddr[AW-1:2];

        always_comb begin
            unique case (i_req.size)
                rv32x_pkg::SZ_BYTE: we = (off == 2'd0);
                rv32x_pkg::SZ_HALF: we = !off[1];
                rv32x_pkg::SZ_WORD: we = 1'b1;
                default:            we = 1'b0;
            endcase
            unique case (off)
                2'd0:    wd = i_req.wdata[7:0];
                2'd1:    wd = i_req.wdata[15:8];
                2'd2:    wd = i_req.wdata[23:16];
                default: wd = i_req.wdata[31:24];
            endcase
        end

        // Clear, write and read the bank
        always_ff @(posedge i_clk) begin
            if (r_state == MS_CLEAR) begin
                r_mem[r_clr_row] <= 8'd0;
            end else if (i_req.wr_en && we) begin
                r_mem[row] <= wd;
            end
            if (i_req.rd_en) begin
                r_q <= r_mem[row];
            end
        end

        assign w_bank_q[b] = r_q;
    end

    // Put the bytes back in access order
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_rdata[8*k +: 8] = w_bank_q[2'(r_lo + 2'(k))];
        end
    end

endmodule

[sv/rv32i_subset_execute_top.sv]
// ----------------------------------------------------------------------------
// rv32i_subset_execute_top
// Executes one RV32I subset instruction per request with its own register
// file and byte data memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries an instruction word and its pc.
//   Output channel (o_valid/i_ready) returns next pc, destination register
//   index, write flag and value, ebreak flag with x10, and an illegal flag.
//   Results leave in request order, one per request.
// Pipeline and throughput:
//   An accepted request passes operand read, execute with memory access and
//   the result register on its way to o_valid. One request is taken per cycle
//   while o_ready stays high; the data memory banks have one read and one
//   write port each, and results are forwarded between stages so that
//   dependent instructions, loads included, need no bubbles.
// Reset:
//   The register file reads as zero. The data memory runs a clearing pass
//   over its MEM_BYTES/4 rows (1024 at 4096 bytes) with o_ready low.
// Stall:
//   With i_ready low the result holds; the two inner stages still fill, then
//   o_ready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_pc,
    output logic [4:0]  o_dest_index,
    output logic        o_dest_written,
    output logic [31:0] o_dest_value,
    output logic        o_halt_hit,
    output logic [31:0] o_halt_code,
    output logic        o_illegal
);

    localparam int AW = rv32x_pkg::MEM_AW;

    // Stage enables
    logic en1;
    logic en2;
    logic en_o;
    logic acc;
    logic mem_ready;

    // Operand stage
    logic        r1_valid;
    logic [31:0] r1_instr;
    logic [31:0] r1_pc;
    logic [4:0]  r1_ra;
    logic [4:0]  r1_rb;
    logic        r1_a_byp;
    logic        r1_b_byp;
    logic [31:0] r1_a_bval;
    logic [31:0] r1_b_bval;

    // Execute stage
    logic        r2_valid;
    logic [4:0]  r2_rd;
    logic        r2_wr;
    logic [31:0] r2_val;
    logic        r2_load;
    logic [2:0]  r2_f3;
    logic [31:0] r2_npc;
    logic        r2_halt;
    logic [31:0] r2_hcode;
    logic        r2_bad;

    // Result register
    logic        r_o_valid;
    logic [31:0] r_o_npc;
    logic [4:0]  r_o_rd;
    logic        r_o_wr;
    logic [31:0] r_o_val;
    logic        r_o_halt;
    logic [31:0] r_o_hcode;
    logic        r_o_bad;

    rv32x_pkg::t_rf_rd   rf_rd;
    rv32x_pkg::t_rf_wr   rf_wr;
    rv32x_pkg::t_mem_req mem_req;
    logic [31:0]         rf_a;
    logic [31:0]         rf_b;
    logic [31:0]         mem_rdata;

    // Execute-stage decode
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_u;
    logic [31:0] imm_s;
    logic [31:0] imm_j;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] pc4;
    logic [31:0] sum_ai;
    logic [31:0] mem_addr;
    logic [4:0]  shamt;
    logic [31:0] x_npc;
    logic [31:0] x_val;
    logic        x_wr;
    logic        x_load;
    logic        x_store;
    logic        x_halt;
    logic        x_bad;
    logic        x_wr_rd;
    logic [31:0] ld_val;
    logic [31:0] s2_val;
    logic        s2_fwd_ok;

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the one after it is free
    // ------------------------------------------------------------------
    assign en_o    = !r_o_valid || i_ready;
    assign en2     = !r2_valid || en_o;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1 && mem_ready;
    assign acc     = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Register file; port A reads x10 for ebreak
    // ------------------------------------------------------------------
    assign rf_rd.en = acc;
    assign rf_rd.ra = (i_instr == rv32x_pkg::EBREAK_WORD) ? rv32x_pkg::HALT_REG
                                                           : i_instr[19:15];
    assign rf_rd.rb = i_instr[24:20];

    assign rf_wr.en   = r2_valid && en_o && r2_wr;
    assign rf_wr.addr = r2_rd;
    assign rf_wr.data = s2_val;

    rv32x_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rf_rd),
        .i_wr      (rf_wr),
        .o_ra_data (rf_a),
        .o_rb_data (rf_b)
    );

    // Capture the request and any result being retired in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_instr  <= i_instr;
            r1_pc     <= i_pc;
            r1_ra     <= rf_rd.ra;
            r1_rb     <= rf_rd.rb;
            r1_a_byp  <= rf_wr.en && (rf_wr.addr == rf_rd.ra);
            r1_b_byp  <= rf_wr.en && (rf_wr.addr == rf_rd.rb);
            r1_a_bval <= s2_val;
            r1_b_bval <= s2_val;
        end
    end

    // ------------------------------------------------------------------
    // Operands: forward from the execute stage, else the captured value
    // ------------------------------------------------------------------
    assign s2_fwd_ok = r2_valid && r2_wr;

    always_comb begin
        opa = r1_a_byp ? r1_a_bval : rf_a;
        opb = r1_b_byp ? r1_b_bval : rf_b;
        if (s2_fwd_ok && (r2_rd == r1_ra)) begin
            opa = s2_val;
        end
        if (s2_fwd_ok && (r2_rd == r1_rb)) begin
            opb = s2_val;
        end
    end

    // ------------------------------------------------------------------
    // Decode and execute
    // ------------------------------------------------------------------
    assign opc   = r1_instr[6:0];
    assign rd    = r1_instr[11:7];
    assign f3    = r1_instr[14:12];
    assign f7    = r1_instr[31:25];
    assign imm_i = {{20{r1_instr[31]}}, r1_instr[31:20]};
    assign imm_u = {r1_instr[31:12], 12'd0};
    assign imm_s = {{20{r1_instr[31]}}, r1_instr[31:25], r1_instr[11:7]};
    assign imm_j = {{11{r1_instr[31]}}, r1_instr[31], r1_instr[19:12],
                    r1_instr[20], r1_instr[30:21], 1'b0};
    assign pc4   = r1_pc + 32'd4;
    assign shamt = opb[4:0];

    assign sum_ai   = opa + imm_i;
    assign mem_addr = opa + ((opc == rv32x_pkg::OPC_STORE) ? imm_s : imm_i);

    always_comb begin
        x_npc   = pc4;
        x_val   = 32'd0;
        x_wr    = 1'b0;
        x_load  = 1'b0;
        x_store = 1'b0;
        x_halt  = 1'b0;
        x_bad   = 1'b0;
        unique case (opc)
            rv32x_pkg::OPC_LUI: begin
                x_val = imm_u;
                x_wr  = 1'b1;
            end
            rv32x_pkg::OPC_AUIPC: begin
                x_val = r1_pc + imm_u;
                x_wr  = 1'b1;
            end
            rv32x_pkg::OPC_LOAD: begin
                if (f3 == rv32x_pkg::F3_B || f3 == rv32x_pkg::F3_H ||
                    f3 == rv32x_pkg::F3_W || f3 == rv32x_pkg::F3_BU ||
                    f3 == rv32x_pkg::F3_HU) begin
                    x_wr   = 1'b1;
                    x_load = 1'b1;
                end else begin
                    x_bad = 1'b1;
                end
            end
            rv32x_pkg::OPC_OPIMM: begin
                if (f3 == rv32x_pkg::F3_ADD) begin
                    x_val = sum_ai;
                    x_wr  = 1'b1;
                end else begin
                    x_bad = 1'b1;
                end
            end
            rv32x_pkg::OPC_JALR: begin
                if (f3 == rv32x_pkg::F3_ADD) begin
                    x_val = pc4;
                    x_wr  = 1'b1;
                    x_npc = {sum_ai[31:1], 1'b0};
                end else begin
                    x_bad = 1'b1;
                end
            end
            rv32x_pkg::OPC_JAL: begin
                x_val = pc4;
                x_wr  = 1'b1;
                x_npc = r1_pc + imm_j;
            end
            rv32x_pkg::OPC_OP: begin
                x_wr = 1'b1;
                if (f7 == rv32x_pkg::F7_BASE) begin
                    unique case (f3)
                        rv32x_pkg::F3_ADD:  x_val = opa + opb;
                        rv32x_pkg::F3_SLL:  x_val = opa << shamt;
                        rv32x_pkg::F3_SLT:  x_val = {31'd0, $signed(opa) < $signed(opb)};
                        rv32x_pkg::F3_SLTU: x_val = {31'd0, opa < opb};
                        rv32x_pkg::F3_XOR:  x_val = opa ^ opb;
                        rv32x_pkg::F3_SR:   x_val = opa >> shamt;
                        rv32x_pkg::F3_OR:   x_val = opa | opb;
                        default:            x_val = opa & opb;
                    endcase
                end else if (f7 == rv32x_pkg::F7_ALT && f3 == rv32x_pkg::F3_ADD) begin
                    x_val = opa - opb;
                end else if (f7 == rv32x_pkg::F7_ALT && f3 == rv32x_pkg::F3_SR) begin
                    x_val = 32'($signed(opa) >>> shamt);
                end else begin
                    x_wr  = 1'b0;
                    x_bad = 1'b1;
                end
            end
            rv32x_pkg::OPC_STORE: begin
                if (f3 == rv32x_pkg::F3_B || f3 == rv32x_pkg::F3_H ||
                    f3 == rv32x_pkg::F3_W) begin
                    x_store = 1'b1;
                end else begin
                    x_bad = 1'b1;
                end
            end
            default: begin
                if (r1_instr == rv32x_pkg::EBREAK_WORD) begin
                    x_halt = 1'b1;
                end else begin
                    x_bad = 1'b1;
                end
            end
        endcase
    end

    // Drop writes to x0
    assign x_wr_rd = x_wr && (rd != 5'd0);

    // ------------------------------------------------------------------
    // Data memory: read and write from the execute stage
    // ------------------------------------------------------------------
    assign mem_req.rd_en = en2;
    assign mem_req.wr_en = r1_valid && en2 && x_store;
    assign mem_req.addr  = mem_addr[AW-1:0];
    assign mem_req.size  = f3[1:0];
    assign mem_req.wdata = opb;

    rv32x_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_ready (mem_ready),
        .o_rdata (mem_rdata)
    );

    // Advance into the memory stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_rd    <= rd;
            r2_wr    <= x_wr_rd;
            r2_val   <= x_wr_rd ? x_val : 32'd0;
            r2_load  <= x_load;
            r2_f3    <= f3;
            r2_npc   <= x_npc;
            r2_halt  <= x_halt;
            r2_hcode <= x_halt ? opa : 32'd0;
            r2_bad   <= x_bad;
        end
    end

    // Extend the loaded bytes
    always_comb begin
        unique case (r2_f3)
            rv32x_pkg::F3_B:  ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
            rv32x_pkg::F3_H:  ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
            rv32x_pkg::F3_W:  ld_val = mem_rdata;
            rv32x_pkg::F3_BU: ld_val = {24'd0, mem_rdata[7:0]};
            rv32x_pkg::F3_HU: ld_val = {16'd0, mem_rdata[15:0]};
            default:          ld_val = 32'd0;
        endcase
    end

    assign s2_val = !r2_wr ? 32'd0 : (r2_load ? ld_val : r2_val);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_npc   <= r2_npc;
            r_o_rd    <= r2_rd;
            r_o_wr    <= r2_wr;
            r_o_val   <= s2_val;
            r_o_halt  <= r2_halt;
            r_o_hcode <= r2_hcode;
            r_o_bad   <= r2_bad;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_next_pc      = r_o_npc;
    assign o_dest_index   = r_o_rd;
    assign o_dest_written = r_o_wr;
    assign o_dest_value   = r_o_val;
    assign o_halt_hit     = r_o_halt;
    assign o_halt_code    = r_o_hcode;
    assign o_illegal      = r_o_bad;

`ifndef NO_ASSERTIONS
    // x0 is never written
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> (rf_wr.addr != 5'd0))
        else $error("register write targets x0");

    // A result is at most one of: register write, halt, illegal
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $onehot0({r_o_wr, r_o_halt, r_o_bad}))
        else $error("result flags overlap");

    // Unwritten results carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_wr) |-> (r_o_val == 32'd0))
        else $error("value reported without a register write");

    // A stalled memory stage keeps its load data
    a_load_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && !en_o) |=> $stable(mem_rdata))
        else $error("load data changed while the memory stage was stalled");

    // No store is issued while the data memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.wr_en) |-> mem_ready)
        else $error("store issued during memory clearing");
`endif

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rv32i_subset_execute_top. Instruction requests are built from
// encoders, so every opcode, funct code, immediate extreme and memory size is
// reached: a directed sequence, store/load sequences that hit and wrap the
// data memory, and a random mix with malformed encodings.
// Every accepted request is run through an in-bench model of the register
// file and byte memory. The expected result is queued and compared field by
// field with what leaves the output channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32x_pkg::*;

    localparam int         CYCLE_LIMIT = 400_000;
    localparam int         TOTAL_REQS  = 1850;
    localparam int         MEM_REQS    = 760;
    localparam logic [2:0] F3_JALR     = 3'b000;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  dest_index;
        logic        dest_written;
        logic [31:0] dest_value;
        logic        halt_hit;
        logic [31:0] halt_code;
        logic        illegal;
    } exec_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [31:0] in_instr  = '0;
    logic [31:0] in_pc     = '0;
    logic        out_ready = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_next_pc;
    logic [4:0]  o_dest_index;
    logic        o_dest_written;
    logic [31:0] o_dest_value;
    logic        o_halt_hit;
    logic [31:0] o_halt_code;
    logic        o_illegal;

    // Architectural state as seen by the predictor
    logic [31:0] arch_regs [0:31];
    logic [7:0]  data_mem  [0:MEM_BYTES-1];

    exec_result_t expected_results [$];
    logic [31:0]  pending_words [$];

    logic [31:0] prog_pc = '0;
    logic        tx_idle = 1'b0;
    logic        rx_idle = 1'b0;

    int requests_sent = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int n_load        = 0;
    int n_store       = 0;
    int n_jump        = 0;
    int n_halt        = 0;
    int n_illegal     = 0;
    int cycle_count   = 0;

    rv32i_subset_execute_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_instr        (in_instr),
        .i_pc           (in_pc),
        .o_valid        (o_valid),
        .i_ready        (out_ready),
        .o_next_pc      (o_next_pc),
        .o_dest_index   (o_dest_index),
        .o_dest_written (o_dest_written),
        .o_dest_value   (o_dest_value),
        .o_halt_hit     (o_halt_hit),
        .o_halt_code    (o_halt_code),
        .o_illegal      (o_illegal)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Instruction encoders
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_u(input logic [6:0] opc, input logic [4:0] rd,
                                          input logic [19:0] imm);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // ------------------------------------------------------------------------
    // Random field pickers
    // ------------------------------------------------------------------------
    // Favour the low registers so that back-to-back dependencies are common
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) == 0)
            return 5'($urandom_range(0, 7));
        return 5'($urandom());
    endfunction

    function automatic logic [11:0] rand_imm12();
        case ($urandom_range(0, 7))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'h000;
            3:       return 12'hFFF;
            4:       return 12'($urandom_range(0, 15));
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic logic [2:0] pick_load_f3();
        case ($urandom_range(0, 4))
            0:       return F3_B;
            1:       return F3_H;
            2:       return F3_W;
            3:       return F3_BU;
            default: return F3_HU;
        endcase
    endfunction

    function automatic logic [2:0] pick_store_f3();
        case ($urandom_range(0, 2))
            0:       return F3_B;
            1:       return F3_H;
            default: return F3_W;
        endcase
    endfunction

    function automatic logic [31:0] rand_op(input logic [4:0] rd, input logic [4:0] rs1,
                                            input logic [4:0] rs2);
        case ($urandom_range(0, 9))
            0:       return enc_r(F7_BASE, F3_ADD,  rd, rs1, rs2);
            1:       return enc_r(F7_BASE, F3_SLL,  rd, rs1, rs2);
            2:       return enc_r(F7_BASE, F3_SLT,  rd, rs1, rs2);
            3:       return enc_r(F7_BASE, F3_SLTU, rd, rs1, rs2);
            4:       return enc_r(F7_BASE, F3_XOR,  rd, rs1, rs2);
            5:       return enc_r(F7_BASE, F3_SR,   rd, rs1, rs2);
            6:       return enc_r(F7_BASE, F3_OR,   rd, rs1, rs2);
            7:       return enc_r(F7_BASE, F3_AND,  rd, rs1, rs2);
            8:       return enc_r(F7_ALT,  F3_ADD,  rd, rs1, rs2);
            default: return enc_r(F7_ALT,  F3_SR,   rd, rs1, rs2);
        endcase
    endfunction

    function automatic logic [31:0] legal_instr();
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        rd  = pick_reg();
        rs1 = pick_reg();
        rs2 = pick_reg();
        case ($urandom_range(0, 15))
            0:       return enc_u(OPC_LUI, rd, 20'($urandom()));
            1:       return enc_u(OPC_AUIPC, rd, 20'($urandom()));
            2, 3:    return enc_i(OPC_LOAD, pick_load_f3(), rd, rs1, rand_imm12());
            4, 5:    return enc_i(OPC_OPIMM, F3_ADD, rd, rs1, rand_imm12());
            6:       return enc_i(OPC_JALR, F3_JALR, rd, rs1, rand_imm12());
            7:       return enc_j(rd, 21'($urandom()));
            8, 9:    return enc_s(pick_store_f3(), rs1, rs2, rand_imm12());
            10:      return EBREAK_WORD;
            default: return rand_op(rd, rs1, rs2);
        endcase
    endfunction

    // Known opcodes with funct fields outside the supported subset
    function automatic logic [31:0] broken_instr();
        logic [31:0] word;
        logic [6:0]  f7;
        logic [2:0]  f3;
        word = $urandom();
        f3   = 3'($urandom());
        case ($urandom_range(0, 6))
            0: begin
                f7 = 7'($urandom());
                if (f7 == F7_BASE || f7 == F7_ALT)
                    f7 = f7 ^ 7'd1;
                return enc_r(f7, f3, word[11:7], word[19:15], word[24:20]);
            end
            1: begin
                if (f3 == F3_ADD || f3 == F3_SR)
                    f3 = F3_OR;
                return enc_r(F7_ALT, f3, word[11:7], word[19:15], word[24:20]);
            end
            2: begin
                while (f3 == F3_B || f3 == F3_H || f3 == F3_W || f3 == F3_BU || f3 == F3_HU)
                    f3 = 3'($urandom());
                return enc_i(OPC_LOAD, f3, word[11:7], word[19:15], word[31:20]);
            end
            3: begin
                while (f3 == F3_B || f3 == F3_H || f3 == F3_W)
                    f3 = 3'($urandom());
                return enc_s(f3, word[19:15], word[24:20], word[31:20]);
            end
            4: begin
                if (f3 == F3_ADD)
                    f3 = F3_SLL;
                return enc_i(OPC_OPIMM, f3, word[11:7], word[19:15], word[31:20]);
            end
            5: begin
                if (f3 == F3_JALR)
                    f3 = F3_SLL;
                return enc_i(OPC_JALR, f3, word[11:7], word[19:15], word[31:20]);
            end
            default: begin
                word[6:0] = EBREAK_WORD[6:0];
                if (word == EBREAK_WORD)
                    word[31] = 1'b1;
                return word;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] mem_load(input logic [31:0] addr, input int nbytes);
        logic [31:0] v;
        logic [31:0] ea;
        v = '0;
        for (int k = 0; k < nbytes; k++) begin
            ea = addr + 32'(k);
            v[8*k +: 8] = data_mem[ea % MEM_BYTES];
        end
        return v;
    endfunction

    task automatic mem_store(input logic [31:0] addr, input int nbytes,
                             input logic [31:0] data);
        logic [31:0] ea;
        for (int k = 0; k < nbytes; k++) begin
            ea = addr + 32'(k);
            data_mem[ea % MEM_BYTES] = data[8*k +: 8];
        end
    endtask

    task automatic execute_instr(input logic [31:0] ins, input logic [31:0] pc,
                                 output exec_result_t r);
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  sh;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] immi;
        logic [31:0] immu;
        logic [31:0] imms;
        logic [31:0] immj;
        logic [31:0] val;
        logic [31:0] raw;
        logic        wr;
        logic        bad;

        opc  = ins[6:0];
        rd   = ins[11:7];
        f3   = ins[14:12];
        f7   = ins[31:25];
        a    = arch_regs[ins[19:15]];
        b    = arch_regs[ins[24:20]];
        sh   = b[4:0];
        immi = {{20{ins[31]}}, ins[31:20]};
        immu = {ins[31:12], 12'b0};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        r    = '0;
        r.next_pc    = pc + 32'd4;
        r.dest_index = rd;
        val  = '0;
        wr   = 1'b0;
        bad  = 1'b0;

        case (opc)
            OPC_LUI: begin
                val = immu;
                wr  = 1'b1;
            end
            OPC_AUIPC: begin
                val = pc + immu;
                wr  = 1'b1;
            end
            OPC_LOAD: begin
                wr = 1'b1;
                case (f3)
                    F3_B: begin
                        raw = mem_load(a + immi, 1);
                        val = {{24{raw[7]}}, raw[7:0]};
                    end
                    F3_H: begin
                        raw = mem_load(a + immi, 2);
                        val = {{16{raw[15]}}, raw[15:0]};
                    end
                    F3_W:  val = mem_load(a + immi, 4);
                    F3_BU: val = mem_load(a + immi, 1);
                    F3_HU: val = mem_load(a + immi, 2);
                    default: begin
                        wr  = 1'b0;
                        bad = 1'b1;
                    end
                endcase
                if (!bad)
                    n_load++;
            end
            OPC_OPIMM: begin
                if (f3 == F3_ADD) begin
                    val = a + immi;
                    wr  = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_JALR: begin
                if (f3 == F3_JALR) begin
                    val = pc + 32'd4;
                    wr  = 1'b1;
                    r.next_pc = (a + immi) & ~32'd1;
                    n_jump++;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_JAL: begin
                val = pc + 32'd4;
                wr  = 1'b1;
                r.next_pc = pc + immj;
                n_jump++;
            end
            OPC_OP: begin
                wr = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << sh;
                        F3_SLT:  val = {31'b0, $signed(a) < $signed(b)};
                        F3_SLTU: val = {31'b0, a < b};
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> sh;
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    val = a - b;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    val = 32'($signed(a) >>> sh);
                end else begin
                    wr  = 1'b0;
                    bad = 1'b1;
                end
            end
            OPC_STORE: begin
                case (f3)
                    F3_B:    mem_store(a + imms, 1, b);
                    F3_H:    mem_store(a + imms, 2, b);
                    F3_W:    mem_store(a + imms, 4, b);
                    default: bad = 1'b1;
                endcase
                if (!bad)
                    n_store++;
            end
            default: begin
                if (ins == EBREAK_WORD) begin
                    r.halt_hit  = 1'b1;
                    r.halt_code = arch_regs[HALT_REG];
                    n_halt++;
                end else begin
                    bad = 1'b1;
                end
            end
        endcase

        // Commit the register result; x0 stays zero
        if (wr && rd != 5'd0) begin
            arch_regs[rd]  = val;
            r.dest_written = 1'b1;
            r.dest_value   = val;
        end
        r.illegal = bad;
        if (bad)
            n_illegal++;
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [31:0] ins);
        int           gap;
        exec_result_t r;
        // Change the idling mix every fifty requests, idle-free stretches included
        if (requests_sent % 50 == 0) begin
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
        end
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_instr <= ins;
        in_pc    <= prog_pc;
        do @(posedge clk); while (!o_ready);
        execute_instr(ins, prog_pc, r);
        expected_results.push_back(r);
        pending_words.push_back(ins);
        prog_pc = r.next_pc;
        requests_sent++;
    endtask

    // Hold off new requests until the output side has caught up
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, then take one result
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_valid);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : check_results
        exec_result_t got;
        exec_result_t want;
        logic [31:0]  word;
        if (rst_n && o_valid && out_ready) begin
            got.next_pc      = o_next_pc;
            got.dest_index   = o_dest_index;
            got.dest_written = o_dest_written;
            got.dest_value   = o_dest_value;
            got.halt_hit     = o_halt_hit;
            got.halt_code    = o_halt_code;
            got.illegal      = o_illegal;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result with no request pending: npc=%h rd=%0d",
                             got.next_pc, got.dest_index);
            end else begin
                want = expected_results.pop_front();
                word = pending_words.pop_front();
                results_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on instr %h: exp npc=%h rd=%0d wr=%b val=%h halt=%b code=%h ill=%b",
                                 word, want.next_pc, want.dest_index, want.dest_written,
                                 want.dest_value, want.halt_hit, want.halt_code, want.illegal);
                        $display("                     got npc=%h rd=%0d wr=%b val=%h halt=%b code=%h ill=%b",
                                 got.next_pc, got.dest_index, got.dest_written,
                                 got.dest_value, got.halt_hit, got.halt_code, got.illegal);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d requests sent, %0d results outstanding",
                     requests_sent, expected_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Every operation at least once, operand extremes, wrapping and misaligned accesses
    task automatic test_directed();
        prog_pc = 32'hFFFF_FFF8;
        send_instr(enc_u(OPC_LUI, 5'd1, 20'hFFFFF));
        send_instr(enc_u(OPC_AUIPC, 5'd4, 20'h80000));
        send_instr(enc_i(OPC_OPIMM, F3_ADD, 5'd2, 5'd0, 12'h7FF));
        send_instr(enc_i(OPC_OPIMM, F3_ADD, 5'd3, 5'd0, 12'h800));
        send_instr(enc_r(F7_BASE, F3_ADD,  5'd5,  5'd1, 5'd2));
        send_instr(enc_r(F7_ALT,  F3_ADD,  5'd6,  5'd0, 5'd2));
        send_instr(enc_r(F7_BASE, F3_SLL,  5'd7,  5'd3, 5'd2));
        send_instr(enc_r(F7_BASE, F3_SR,   5'd8,  5'd3, 5'd2));
        send_instr(enc_r(F7_ALT,  F3_SR,   5'd9,  5'd3, 5'd2));
        send_instr(enc_r(F7_BASE, F3_SLT,  5'd11, 5'd3, 5'd2));
        send_instr(enc_r(F7_BASE, F3_SLTU, 5'd12, 5'd3, 5'd2));
        send_instr(enc_r(F7_BASE, F3_XOR,  5'd13, 5'd1, 5'd3));
        send_instr(enc_r(F7_BASE, F3_OR,   5'd14, 5'd1, 5'd2));
        send_instr(enc_r(F7_BASE, F3_AND,  5'd15, 5'd1, 5'd3));
        // word store straddling the top of memory, read back at every size
        send_instr(enc_i(OPC_OPIMM, F3_ADD, 5'd16, 5'd0, 12'hFFE));
        send_instr(enc_s(F3_W, 5'd16, 5'd5, 12'h000));
        send_instr(enc_i(OPC_LOAD, F3_W,  5'd17, 5'd16, 12'h000));
        send_instr(enc_i(OPC_LOAD, F3_B,  5'd18, 5'd16, 12'h001));
        send_instr(enc_i(OPC_LOAD, F3_BU, 5'd19, 5'd16, 12'h001));
        send_instr(enc_i(OPC_LOAD, F3_H,  5'd20, 5'd16, 12'h001));
        send_instr(enc_i(OPC_LOAD, F3_HU, 5'd21, 5'd16, 12'h001));
        send_instr(enc_s(F3_B, 5'd0, 5'd6, 12'h7FF));
        send_instr(enc_s(F3_H, 5'd0, 5'd3, 12'hFFF));
        // halt reports x10
        send_instr(enc_i(OPC_OPIMM, F3_ADD, HALT_REG, 5'd5, 12'h000));
        send_instr(EBREAK_WORD);
        // furthest backward jump, then an odd register target
        send_instr(enc_j(5'd1, 21'h100000));
        send_instr(enc_i(OPC_JALR, F3_JALR, 5'd22, 5'd2, 12'h000));
        send_instr(32'hFFFF_FFFF);
    endtask

    // Store then load near the same address, with fillers in between
    task automatic test_memory_sequences();
        logic [4:0]  base;
        logic [4:0]  src;
        logic [4:0]  dst;
        logic [11:0] imm;
        int          delta;
        while (requests_sent < MEM_REQS) begin
            base = pick_reg();
            if (base != 5'd0 && $urandom_range(0, 3) == 0)
                send_instr(enc_i(OPC_OPIMM, F3_ADD, base, pick_reg(), rand_imm12()));
            src = pick_reg();
            if (src != base && src != 5'd0 && $urandom_range(0, 1) == 0) begin
                send_instr(enc_u(OPC_LUI, src, 20'($urandom())));
                send_instr(enc_i(OPC_OPIMM, F3_ADD, src, src, rand_imm12()));
            end
            imm = rand_imm12();
            // now and then break the sequence with a malformed or random word
            if ($urandom_range(0, 7) == 0)
                send_instr($urandom_range(0, 1) ? broken_instr() : $urandom());
            send_instr(enc_s(pick_store_f3(), base, src, imm));
            repeat ($urandom_range(0, 2)) begin
                dst = pick_reg();
                if (dst != base)
                    send_instr(rand_op(dst, pick_reg(), pick_reg()));
            end
            delta = $urandom_range(0, 6) - 3;
            send_instr(enc_i(OPC_LOAD, pick_load_f3(), pick_reg(), base, imm + delta[11:0]));
        end
    endtask

    // Mostly legal instructions, some malformed encodings and raw noise
    task automatic test_random_mix();
        while (requests_sent < TOTAL_REQS) begin
            if ($urandom_range(0, 15) == 0)
                prog_pc = $urandom();
            case ($urandom_range(0, 19))
                0:       send_instr($urandom());
                1, 2:    send_instr(broken_instr());
                default: send_instr(legal_instr());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++)
            data_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_for_results();
        test_memory_sequences();
        test_random_mix();
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("%0d instruction requests, %0d results checked, %0d mismatches",
                 requests_sent, results_seen, mismatches);
        $display("executed %0d loads, %0d stores, %0d jumps, %0d halts, %0d illegal words",
                 n_load, n_store, n_jump, n_halt, n_illegal);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
